[hw/rtl/trace_route_stamper_assert.svh]
// Assertion macros shared by the trace route stamper RTL.
`ifndef TRACE_ROUTE_STAMPER_ASSERT_SVH
`define TRACE_ROUTE_STAMPER_ASSERT_SVH

// Check an implication in the same cycle, sampled on clk_i, off during reset.
`define TRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle, sampled on clk_i, off during reset.
`define TRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/trs_pkg.sv]
// Package of shared constants, codes and helpers for the trace route stamper.
`default_nettype none

package trs_pkg;

  // Default geometry of the monitoring region and noise window
  localparam int TRACE_SLOTS_DEF  = 8;
  localparam int LINK_SLOTS_DEF   = 8;
  localparam int NOISE_WINDOW_DEF = 5;

  // Fixed field widths
  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 16;
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_REGION = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NOISE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MEAN   = 2'd2;

  // Result kinds
  localparam logic KIND_REGION = 1'b0;
  localparam logic KIND_MEAN   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LQ_MODE   = 1'd1;

  // Markers and limits
  localparam logic [WORD_W-1:0] TRACE_LIMIT = 16'd1111;
  localparam logic [WORD_W-1:0] EMPTY_LINK  = 16'hffff;
  localparam logic [BYTE_W-1:0] EMPTY_NOISE = 8'hff;
  localparam logic [BYTE_W-1:0] COUNT_LAST  = 8'd254;

  // Merge the node address into a free trace word
  function automatic logic [WORD_W-1:0] stamp_word(input logic [WORD_W-1:0] w,
                                                   input logic [BYTE_W-1:0] a);
    logic [WORD_W-1:0] r;
    if (w == '0) begin
      r = {8'h00, a};
    end else if (w < 16'd16) begin
      r = w | {4'h0, a, 4'h0};
    end else if (w < 16'd256) begin
      r = w | {a, 8'h00};
    end else begin
      r = w | {a[3:0], 12'h000};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/trs_ram.sv]
// Generic single write port RAM with one registered read port.
`default_nettype none

module trs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/trace_route_stamper.sv]
// Trace route stamper: buffers a monitoring region, stamps the trace, emits it.
// After last, a scan reads base + 2*TRACE_SLOTS buffer bytes, one per cycle through the buffer RAM
// port; then each byte is fetched only after the previous one is loaded and the output register has room.
// A noise sample holds the input until the mean division has finished.
// A mean request answers in the output register at the next edge.
// Reset clears counts, pointers and control; the mean reads 255; buffer and ring start unknown.
`default_nettype none
`include "trace_route_stamper_assert.svh"

module trace_route_stamper #(
  parameter int TRACE_SLOTS  = trs_pkg::TRACE_SLOTS_DEF,
  parameter int LINK_SLOTS   = trs_pkg::LINK_SLOTS_DEF,
  parameter int NOISE_WINDOW = trs_pkg::NOISE_WINDOW_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input words
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [trs_pkg::REQ_W-1:0]      req_type_i,
  input  wire logic [trs_pkg::BYTE_W-1:0]     data_byte_i,
  input  wire logic                           last_i,
  input  wire logic [trs_pkg::WORD_W-1:0]     link_rssi_lqi_i,
  // output words
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                out_kind_o,
  output logic      [trs_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                                out_last_o,
  output logic                                stamped_o,
  // configuration writes
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [trs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [trs_pkg::CFG_DAT_W-1:0]  cfg_data_i
);

  localparam int RegionMax = 3 * LINK_SLOTS + 2 * TRACE_SLOTS;
  localparam int AW  = $clog2(RegionMax);
  localparam int CW  = $clog2(RegionMax + 1);
  localparam int SW  = 8 + $clog2(NOISE_WINDOW);
  localparam int NW  = $clog2(NOISE_WINDOW + 1);
  localparam int PW  = (NOISE_WINDOW > 1) ? $clog2(NOISE_WINDOW) : 1;
  localparam int StW = $clog2(SW + 1);

  localparam logic [AW-1:0] LinkEnd   = AW'(2 * LINK_SLOTS);
  localparam logic [AW-1:0] NoiseEnd  = AW'(3 * LINK_SLOTS);
  localparam logic [CW-1:0] ScanLastL = CW'(RegionMax - 1);
  localparam logic [CW-1:0] ScanLastP = CW'(2 * TRACE_SLOTS - 1);
  localparam logic [CW-1:0] CntMax    = CW'(RegionMax);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SWAIT, S_EMIT} state_e;

  state_e state_q, state_d;

  // configuration
  logic [7:0] node_addr_q;
  logic       lq_mode_q;

  // region bookkeeping
  logic [CW-1:0] byte_cnt_q, byte_cnt_d;
  logic [15:0]   rl_q, rl_d;

  // noise ring and mean divider
  logic [7:0]     ring_q [NOISE_WINDOW];
  logic [PW-1:0]  ring_ptr_q, ring_ptr_d;
  logic [7:0]     smp_cnt_q, smp_cnt_d;
  logic           div_load_q, div_load_d;
  logic           div_run_q, div_run_d;
  logic [SW-1:0]  dvd_q, dvd_d;
  logic [NW-1:0]  rem_q, rem_d;
  logic [StW-1:0] step_q, step_d;
  logic [7:0]     mean_q, mean_d;
  logic [NW-1:0]  div_n;
  logic [SW-1:0]  div_sum;
  logic [NW:0]    div_t;
  logic           div_ge;
  logic [SW-1:0]  quo_next;

  // scan pass
  logic [AW-1:0] scan_a_q, scan_a_d;
  logic          sc_vld_q, sc_vld_d;
  logic [AW-1:0] sc_ar_q, sc_ar_d;
  logic [7:0]    prev_q, prev_d;
  logic [7:0]    sc_byte;
  logic [AW-1:0] tr_base, tr_rel;
  logic [CW-1:0] scan_last;
  logic          tr_cand, lk_cand, nz_cand;
  logic          tr_hit_q, tr_hit_d, lk_hit_q, lk_hit_d, nz_hit_q, nz_hit_d;
  logic [AW-1:0] tr_addr_q, tr_addr_d, lk_addr_q, lk_addr_d, nz_addr_q, nz_addr_d;
  logic [15:0]   tr_word_q, tr_word_d;

  // emit pass
  logic [AW-1:0] em_a_q, em_a_d;
  logic          em_pend_q, em_pend_d;
  logic [AW-1:0] em_ar_q, em_ar_d;
  logic          em_last_q, em_last_d;
  logic [7:0]    em_byte;

  // output register
  logic       out_valid_q, out_valid_d;
  logic       out_kind_q, out_kind_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       out_stamp_q, out_stamp_d;

  // buffer RAM port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic in_acc, ring_we;

  trs_ram #(
    .WIDTH(8),
    .DEPTH(RegionMax)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(byte_cnt_q[AW-1:0]),
    .wdata_i(data_byte_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Hold input while busy, dividing, draining or with a blocked result
  assign in_stall_o = (state_q != S_IDLE) || div_load_q || div_run_q || em_pend_q ||
                      (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Sum the populated head of the ring
  always_comb begin
    div_n = (smp_cnt_q >= 8'(NOISE_WINDOW)) ? NW'(NOISE_WINDOW) : smp_cnt_q[NW-1:0];
    div_sum = '0;
    for (int k = 0; k < NOISE_WINDOW; k++) begin
      if (k < int'(div_n)) begin
        div_sum = div_sum + SW'(ring_q[k]);
      end
    end
  end

  // One restoring division step
  assign div_t    = {rem_q, dvd_q[SW-1]};
  assign div_ge   = div_t >= {1'b0, div_n};
  assign quo_next = {dvd_q[SW-2:0], div_ge};

  // Scan byte, with positions past the received bytes reading zero
  assign sc_byte   = (CW'(sc_ar_q) < byte_cnt_q) ? ram_rdata : 8'h00;
  assign tr_base   = lq_mode_q ? NoiseEnd : '0;
  assign tr_rel    = sc_ar_q - tr_base;
  assign scan_last = lq_mode_q ? ScanLastL : ScanLastP;
  assign tr_cand   = sc_vld_q && !tr_hit_q && (sc_ar_q >= tr_base) && tr_rel[0] &&
                     ({prev_q, sc_byte} < trs_pkg::TRACE_LIMIT);
  assign lk_cand   = sc_vld_q && lq_mode_q && !lk_hit_q && (sc_ar_q < LinkEnd) &&
                     sc_ar_q[0] && ({sc_byte, prev_q} == trs_pkg::EMPTY_LINK);
  assign nz_cand   = sc_vld_q && lq_mode_q && !nz_hit_q && (sc_ar_q >= LinkEnd) &&
                     (sc_ar_q < NoiseEnd) && (sc_byte == trs_pkg::EMPTY_NOISE);

  // Substitute the edits into the emitted byte, only once a trace slot was hit
  always_comb begin
    em_byte = ram_rdata;
    if (tr_hit_q) begin
      if (em_ar_q == tr_addr_q) begin
        em_byte = tr_word_q[15:8];
      end else if (em_ar_q == tr_addr_q + AW'(1)) begin
        em_byte = tr_word_q[7:0];
      end else if (lk_hit_q && (em_ar_q == lk_addr_q)) begin
        em_byte = rl_q[7:0];
      end else if (lk_hit_q && (em_ar_q == lk_addr_q + AW'(1))) begin
        em_byte = rl_q[15:8];
      end else if (nz_hit_q && (em_ar_q == nz_addr_q)) begin
        em_byte = mean_q;
      end
    end
  end

  // Next state of the sequencer, divider and output register
  always_comb begin
    state_d     = state_q;
    byte_cnt_d  = byte_cnt_q;
    rl_d        = rl_q;
    ring_ptr_d  = ring_ptr_q;
    smp_cnt_d   = smp_cnt_q;
    ring_we     = 1'b0;
    div_load_d  = 1'b0;
    div_run_d   = div_run_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    step_d      = step_q;
    mean_d      = mean_q;
    scan_a_d    = scan_a_q;
    sc_vld_d    = 1'b0;
    sc_ar_d     = sc_ar_q;
    prev_d      = prev_q;
    tr_hit_d    = tr_hit_q;
    tr_addr_d   = tr_addr_q;
    tr_word_d   = tr_word_q;
    lk_hit_d    = lk_hit_q;
    lk_addr_d   = lk_addr_q;
    nz_hit_d    = nz_hit_q;
    nz_addr_d   = nz_addr_q;
    em_a_d      = em_a_q;
    em_pend_d   = 1'b0;
    em_ar_d     = em_ar_q;
    em_last_d   = em_last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_stamp_d = out_stamp_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = scan_a_q;

    // Accept a request word
    if (in_acc) begin
      case (req_type_i)
        trs_pkg::REQ_REGION: begin
          if (byte_cnt_q < CntMax) begin
            ram_we     = 1'b1;
            byte_cnt_d = byte_cnt_q + CW'(1);
          end
          if (last_i) begin
            state_d  = S_SCAN;
            scan_a_d = '0;
            rl_d     = link_rssi_lqi_i;
            tr_hit_d = 1'b0;
            lk_hit_d = 1'b0;
            nz_hit_d = 1'b0;
          end
        end
        trs_pkg::REQ_NOISE: begin
          ring_we    = 1'b1;
          ring_ptr_d = (ring_ptr_q == PW'(NOISE_WINDOW - 1)) ? '0 : ring_ptr_q + PW'(1);
          smp_cnt_d  = (smp_cnt_q == trs_pkg::COUNT_LAST) ? '0 : smp_cnt_q + 8'd1;
          div_load_d = 1'b1;
        end
        trs_pkg::REQ_MEAN: begin
          out_valid_d = 1'b1;
          out_kind_d  = trs_pkg::KIND_MEAN;
          out_byte_d  = mean_q;
          out_last_d  = 1'b0;
          out_stamp_d = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // Start the mean division, or report no samples
    if (div_load_q) begin
      if (div_n == '0) begin
        mean_d = trs_pkg::EMPTY_NOISE;
      end else begin
        dvd_d     = div_sum;
        rem_d     = '0;
        step_d    = StW'(SW);
        div_run_d = 1'b1;
      end
    end

    // Advance the division by one quotient bit
    if (div_run_q) begin
      rem_d  = div_ge ? NW'(div_t - {1'b0, div_n}) : div_t[NW-1:0];
      dvd_d  = quo_next;
      step_d = step_q - StW'(1);
      if (step_q == StW'(1)) begin
        div_run_d = 1'b0;
        mean_d    = quo_next[7:0];
      end
    end

    // Record the first hits of the scan
    if (sc_vld_q) begin
      prev_d = sc_byte;
      if (tr_cand) begin
        tr_hit_d  = 1'b1;
        tr_addr_d = sc_ar_q - AW'(1);
        tr_word_d = trs_pkg::stamp_word({prev_q, sc_byte}, node_addr_q);
      end
      if (lk_cand) begin
        lk_hit_d  = 1'b1;
        lk_addr_d = sc_ar_q - AW'(1);
      end
      if (nz_cand) begin
        nz_hit_d  = 1'b1;
        nz_addr_d = sc_ar_q;
      end
    end

    // Load a fetched region byte into the output register
    if (em_pend_q) begin
      out_valid_d = 1'b1;
      out_kind_d  = trs_pkg::KIND_REGION;
      out_byte_d  = em_byte;
      out_last_d  = em_last_q;
      out_stamp_d = tr_hit_q;
    end

    case (state_q)
      S_IDLE: begin
      end
      S_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = scan_a_q;
        sc_vld_d  = 1'b1;
        sc_ar_d   = scan_a_q;
        scan_a_d  = scan_a_q + AW'(1);
        if (CW'(scan_a_q) == scan_last) begin
          state_d = S_SWAIT;
        end
      end
      S_SWAIT: begin
        state_d = S_EMIT;
        em_a_d  = '0;
      end
      S_EMIT: begin
        if (!em_pend_q && (!out_valid_q || !out_stall_i)) begin
          ram_re    = 1'b1;
          ram_raddr = em_a_q;
          em_pend_d = 1'b1;
          em_ar_d   = em_a_q;
          em_a_d    = em_a_q + AW'(1);
          em_last_d = (CW'(em_a_q) == byte_cnt_q - CW'(1));
          if (CW'(em_a_q) == byte_cnt_q - CW'(1)) begin
            state_d    = S_IDLE;
            byte_cnt_d = '0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state, control and the output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      node_addr_q <= '0;
      lq_mode_q   <= 1'b0;
      byte_cnt_q  <= '0;
      ring_ptr_q  <= '0;
      smp_cnt_q   <= '0;
      div_load_q  <= 1'b0;
      div_run_q   <= 1'b0;
      step_q      <= '0;
      mean_q      <= trs_pkg::EMPTY_NOISE;
      scan_a_q    <= '0;
      sc_vld_q    <= 1'b0;
      tr_hit_q    <= 1'b0;
      lk_hit_q    <= 1'b0;
      nz_hit_q    <= 1'b0;
      em_a_q      <= '0;
      em_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      byte_cnt_q  <= byte_cnt_d;
      ring_ptr_q  <= ring_ptr_d;
      smp_cnt_q   <= smp_cnt_d;
      div_load_q  <= div_load_d;
      div_run_q   <= div_run_d;
      step_q      <= step_d;
      mean_q      <= mean_d;
      scan_a_q    <= scan_a_d;
      sc_vld_q    <= sc_vld_d;
      tr_hit_q    <= tr_hit_d;
      lk_hit_q    <= lk_hit_d;
      nz_hit_q    <= nz_hit_d;
      em_a_q      <= em_a_d;
      em_pend_q   <= em_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          trs_pkg::CFG_NODE_ADDR: node_addr_q <= cfg_data_i;
          trs_pkg::CFG_LQ_MODE:   lq_mode_q   <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Hold payload registers
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[ring_ptr_q] <= data_byte_i;
    end
    rl_q        <= rl_d;
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    sc_ar_q     <= sc_ar_d;
    prev_q      <= prev_d;
    tr_addr_q   <= tr_addr_d;
    tr_word_q   <= tr_word_d;
    lk_addr_q   <= lk_addr_d;
    nz_addr_q   <= nz_addr_d;
    em_ar_q     <= em_ar_d;
    em_last_q   <= em_last_d;
    out_kind_q  <= out_kind_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_stamp_q <= out_stamp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign stamped_o   = out_stamp_q;

  // Checks on buffer fill, divider start, result loading and answers
  `TRS_ASSERT_NOW(a_cnt_bound, 1'b1, byte_cnt_q <= CntMax, "byte count past region size")
  `TRS_ASSERT_NEXT(a_div_start, in_acc && (req_type_i == trs_pkg::REQ_NOISE), div_load_q,
                   "noise sample did not start the mean update")
  `TRS_ASSERT_NOW(a_em_room, em_pend_q, !out_valid_q || !out_stall_i,
                  "fetched region byte has no room in the output register")
  `TRS_ASSERT_NOW(a_mean_flags, out_valid_q && (out_kind_q == trs_pkg::KIND_MEAN),
                  !out_last_q && !out_stamp_q, "mean answer carries region flags")

endmodule

`default_nettype wire
